@@ hw/rtl/aarm_pkg.sv @@
// Package for the axis-angle rotation matrix pipeline: formats, CORDIC tables,
// stage payload types and the saturation helper.
// No dependencies.
package aarm_pkg;

  localparam int CordicStages = 16;
  localparam int AtanCount    = 24;
  localparam int SqrtSteps    = 32;
  localparam int DivSteps     = 17;
  // Input, two angle stages, CORDIC, trig rounding, root, divide, unit clamp,
  // two product stages and the output register.
  localparam int Latency      = CordicStages + SqrtSteps + DivSteps + 8;

  localparam logic signed [17:0] OneQ16    = 18'sd65536;
  localparam logic signed [17:0] ZeroQ16   = 18'sd0;
  localparam logic [16:0]        TurnUnits = 17'd23040;
  localparam logic signed [17:0] AngleBias = 18'sd46080;

  // Binary angle = r * 2^23 / 45 split as r * 186413 + (23 r + 22) / 45, the
  // last quotient taken by a reciprocal multiply that is exact below 2^20.
  localparam logic [32:0] BamMulHi   = 33'd186413;
  localparam logic [19:0] BamRemMul  = 20'd23;
  localparam logic [19:0] BamRemAdd  = 20'd22;
  localparam logic [40:0] BamRecip   = 41'd1491309;
  localparam int          BamShift   = 26;

  localparam logic [1:0] QuadFirst  = 2'd0;
  localparam logic [1:0] QuadSecond = 2'd1;
  localparam logic [1:0] QuadThird  = 2'd2;
  localparam logic [1:0] QuadFourth = 2'd3;

  localparam logic [29:0] AtanBam [AtanCount] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  // CORDIC gain times 2^30, the root of its square, worked out at elaboration.
  function automatic logic [63:0] gain_root(input int n);
    logic [63:0] g;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    g = 64'd1 << 30;
    for (int i = 0; i < n; i++) begin
      g = g + (g >> (2 * i));
    end
    v   = g << 30;
    res = 64'd0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  localparam logic [63:0] CordicKFull = (64'd1 << 60) / gain_root(CordicStages);
  localparam logic signed [33:0] CordicK = $signed(CordicKFull[33:0]);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        n2;
  } axis_t;

  typedef struct packed {
    logic signed [17:0] s;
    logic signed [17:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } cord_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0]       r;
    logic [2:0][31:0]  rem;
    logic [2:0][16:0]  q;
    logic [2:0][16:0]  dl;
  } div_t;

  function automatic logic signed [17:0] sat_q16(input logic signed [23:0] v);
    logic signed [17:0] res;
    if (v > 24'sd65536) begin
      res = OneQ16;
    end else if (v < -24'sd65536) begin
      res = -OneQ16;
    end else begin
      res = v[17:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/axis_angle_rotation_matrix.sv @@
// Axis-angle rotation matrix: a fully pipelined Rodrigues matrix builder.
// Depends on aarm_pkg for formats, CORDIC tables and stage payload types.
//
//   channel   ports                                   handshake
//   request   angle_i, axis_x_i, axis_y_i, axis_z_i   start_i high, busy_o low
//   result    m00_o .. m22_o, zero_axis_o             done_o high for one cycle
//
// One request may enter on every clock; busy_o is never raised.
// The delay from a request beat to its result, Latency in aarm_pkg, is set by
// the bit-per-stage square root (32 stages), the 17-stage restoring divider
// and the CORDIC stages, all in one line.
// Reset clears only the valid bits that travel with each beat.
// The receiver cannot stall, so nothing in the pipe ever holds.
module axis_angle_rotation_matrix
  import aarm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] angle_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               done_o,
  output logic signed [17:0] m00_o,
  output logic signed [17:0] m01_o,
  output logic signed [17:0] m02_o,
  output logic signed [17:0] m10_o,
  output logic signed [17:0] m11_o,
  output logic signed [17:0] m12_o,
  output logic signed [17:0] m20_o,
  output logic signed [17:0] m21_o,
  output logic signed [17:0] m22_o,
  output logic               zero_axis_o
);

  assign busy_o = 1'b0;

  // ---------------------------------------------------------------- stage 1
  logic        accept;
  logic        s1_v_q;
  logic [14:0] s1_r_d, s1_r_q;
  axis_t       s1_ax_d, s1_ax_q;
  logic signed [17:0] ang_b;
  logic [16:0] a0, a1, a2, a3;
  logic [31:0] sqx, sqy, sqz;

  assign accept = start_i && !busy_o;

  always_comb begin
    ang_b = 18'(angle_i) + AngleBias;
    a0 = ang_b[16:0];
    a1 = (a0 >= TurnUnits) ? a0 - TurnUnits : a0;
    a2 = (a1 >= TurnUnits) ? a1 - TurnUnits : a1;
    a3 = (a2 >= TurnUnits) ? a2 - TurnUnits : a2;
    s1_r_d = a3[14:0];
    sqx = 32'(32'(axis_x_i) * 32'(axis_x_i));
    sqy = 32'(32'(axis_y_i) * 32'(axis_y_i));
    sqz = 32'(32'(axis_z_i) * 32'(axis_z_i));
    s1_ax_d.x  = axis_x_i;
    s1_ax_d.y  = axis_y_i;
    s1_ax_d.z  = axis_z_i;
    s1_ax_d.n2 = sqx + sqy + sqz;
  end

  // ---------------------------------------------------------------- stage 2
  logic        s2_v_q;
  logic [32:0] s2_hi_d, s2_hi_q;
  logic [40:0] s2_lo_d, s2_lo_q;
  logic [19:0] bam_rem;
  axis_t       s2_ax_q;

  always_comb begin
    bam_rem = BamRemMul * 20'(s1_r_q) + BamRemAdd;
    s2_hi_d = 33'(s1_r_q) * BamMulHi;
    s2_lo_d = 41'(bam_rem) * BamRecip;
  end

  // ---------------------------------------------------------------- stage 3
  logic        s3_v_q;
  logic [31:0] s3_bam_d, s3_bam_q;
  logic [32:0] bam_sum;
  axis_t       s3_ax_q;

  always_comb begin
    bam_sum  = s2_hi_q + 33'(s2_lo_q >> BamShift);
    s3_bam_d = bam_sum[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q   <= s1_r_d;
    s1_ax_q  <= s1_ax_d;
    s2_hi_q  <= s2_hi_d;
    s2_lo_q  <= s2_lo_d;
    s2_ax_q  <= s1_ax_q;
    s3_bam_q <= s3_bam_d;
    s3_ax_q  <= s2_ax_q;
  end

  // ---------------------------------------------------------------- CORDIC
  cord_t cord0;
  cord_t cord_q    [CordicStages];
  logic  cord_v_q  [CordicStages];
  axis_t cord_ax_q [CordicStages];

  always_comb begin
    cord0.x    = CordicK;
    cord0.y    = 34'sd0;
    cord0.z    = $signed({3'b000, s3_bam_q[29:0]});
    cord0.quad = s3_bam_q[31:30];
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_cordic
    cord_t in_s, cord_d;
    logic  in_v;
    axis_t in_ax;
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;

    if (i == 0) begin : g_first
      assign in_s  = cord0;
      assign in_v  = s3_v_q;
      assign in_ax = s3_ax_q;
    end else begin : g_next
      assign in_s  = cord_q[i-1];
      assign in_v  = cord_v_q[i-1];
      assign in_ax = cord_ax_q[i-1];
    end

    always_comb begin
      dx = in_s.y >>> i;
      dy = in_s.x >>> i;
      at = $signed({3'b000, AtanBam[i]});
      cord_d.quad = in_s.quad;
      if (!in_s.z[32]) begin
        cord_d.x = in_s.x - dx;
        cord_d.y = in_s.y + dy;
        cord_d.z = in_s.z - at;
      end else begin
        cord_d.x = in_s.x + dx;
        cord_d.y = in_s.y - dy;
        cord_d.z = in_s.z + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cord_v_q[i] <= 1'b0;
      end else begin
        cord_v_q[i] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      cord_q[i]    <= cord_d;
      cord_ax_q[i] <= in_ax;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic  s4_v_q;
  trig_t s4_tr_d, s4_tr_q;
  axis_t s4_ax_q;
  cord_t cl;
  logic signed [33:0] xr, yr;
  logic signed [17:0] c0, s0;

  always_comb begin
    cl = cord_q[CordicStages-1];
    xr = cl.x + 34'sd8192;
    yr = cl.y + 34'sd8192;
    // Near the quadrant edges the CORDIC can end just below zero, so the
    // rounded value keeps its sign.
    c0 = sat_q16(24'($signed(xr[33:14])));
    s0 = sat_q16(24'($signed(yr[33:14])));
    unique case (cl.quad)
      QuadFirst:  begin s4_tr_d.c = c0;  s4_tr_d.s = s0;  end
      QuadSecond: begin s4_tr_d.c = -s0; s4_tr_d.s = c0;  end
      QuadThird:  begin s4_tr_d.c = -c0; s4_tr_d.s = -s0; end
      QuadFourth: begin s4_tr_d.c = s0;  s4_tr_d.s = -c0; end
      default:    begin s4_tr_d.c = c0;  s4_tr_d.s = s0;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= cord_v_q[CordicStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s4_tr_q <= s4_tr_d;
    s4_ax_q <= cord_ax_q[CordicStages-1];
  end

  // ---------------------------------------------------------------- root
  // Floor square root of n2 * 2^32, one result bit per stage.
  sqrt_t sq_q    [SqrtSteps];
  logic  sq_v_q  [SqrtSteps];
  axis_t sq_ax_q [SqrtSteps];
  trig_t sq_tr_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    sqrt_t in_s, sq_d;
    logic  in_v;
    axis_t in_ax;
    trig_t in_tr;
    logic [1:0]  chunk;
    logic [35:0] rem_sh, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign in_s  = '0;
      assign in_v  = s4_v_q;
      assign in_ax = s4_ax_q;
      assign in_tr = s4_tr_q;
    end else begin : g_next
      assign in_s  = sq_q[k-1];
      assign in_v  = sq_v_q[k-1];
      assign in_ax = sq_ax_q[k-1];
      assign in_tr = sq_tr_q[k-1];
    end

    if (k < 16) begin : g_bits
      assign chunk = in_ax.n2[31-2*k -: 2];
    end else begin : g_zero
      assign chunk = 2'b00;
    end

    always_comb begin
      rem_sh = {in_s.rem[33:0], chunk};
      trial  = {2'b00, in_s.root, 2'b01};
      ge     = rem_sh >= trial;
      sq_d.rem  = ge ? rem_sh - trial : rem_sh;
      sq_d.root = {in_s.root[30:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else begin
        sq_v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[k]    <= sq_d;
      sq_ax_q[k] <= in_ax;
      sq_tr_q[k] <= in_tr;
    end
  end

  // ---------------------------------------------------------------- divide
  // Unit component = (|a| * 2^32 + r/2) / r, one quotient bit per stage.
  div_t  div0;
  axis_t sq_ax_l;
  logic signed [15:0] axv [3];
  logic [15:0] mag   [3];
  logic [47:0] dvd   [3];

  assign sq_ax_l = sq_ax_q[SqrtSteps-1];
  assign axv[0]  = sq_ax_l.x;
  assign axv[1]  = sq_ax_l.y;
  assign axv[2]  = sq_ax_l.z;

  always_comb begin
    div0.r = sq_q[SqrtSteps-1].root;
    for (int c = 0; c < 3; c++) begin
      mag[c] = axv[c][15] ? 16'(-axv[c]) : 16'(axv[c]);
      dvd[c] = {mag[c], 32'd0} + {17'd0, div0.r[31:1]};
      div0.rem[c] = {1'b0, dvd[c][47:17]};
      div0.q[c]   = 17'd0;
      div0.dl[c]  = dvd[c][16:0];
    end
  end

  div_t  dv_q    [DivSteps];
  logic  dv_v_q  [DivSteps];
  axis_t dv_ax_q [DivSteps];
  trig_t dv_tr_q [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    div_t  in_s, dv_d;
    logic  in_v;
    axis_t in_ax;
    trig_t in_tr;
    logic [32:0] rem_sh [3];
    logic [32:0] diff   [3];
    logic        ge     [3];

    if (j == 0) begin : g_first
      assign in_s  = div0;
      assign in_v  = sq_v_q[SqrtSteps-1];
      assign in_ax = sq_ax_l;
      assign in_tr = sq_tr_q[SqrtSteps-1];
    end else begin : g_next
      assign in_s  = dv_q[j-1];
      assign in_v  = dv_v_q[j-1];
      assign in_ax = dv_ax_q[j-1];
      assign in_tr = dv_tr_q[j-1];
    end

    always_comb begin
      dv_d.r = in_s.r;
      for (int c = 0; c < 3; c++) begin
        rem_sh[c] = {in_s.rem[c], in_s.dl[c][DivSteps-1-j]};
        diff[c]   = rem_sh[c] - {1'b0, in_s.r};
        ge[c]     = rem_sh[c] >= {1'b0, in_s.r};
        dv_d.rem[c] = ge[c] ? diff[c][31:0] : rem_sh[c][31:0];
        dv_d.q[c]   = {in_s.q[c][15:0], ge[c]};
        dv_d.dl[c]  = in_s.dl[c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else begin
        dv_v_q[j] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[j]    <= dv_d;
      dv_ax_q[j] <= in_ax;
      dv_tr_q[j] <= in_tr;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic  s6_v_q;
  logic  s6_zero_q;
  trig_t s6_tr_q;
  logic signed [17:0] u_d [3];
  logic signed [17:0] u_q [3];
  logic [16:0] qc [3];
  logic        neg [3];
  axis_t dv_ax_l;

  assign dv_ax_l = dv_ax_q[DivSteps-1];
  assign neg[0]  = dv_ax_l.x[15];
  assign neg[1]  = dv_ax_l.y[15];
  assign neg[2]  = dv_ax_l.z[15];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qc[c]  = (dv_q[DivSteps-1].q[c] > 17'd65536) ? 17'd65536 : dv_q[DivSteps-1].q[c];
      u_d[c] = neg[c] ? -$signed({1'b0, qc[c]}) : $signed({1'b0, qc[c]});
    end
  end

  // ---------------------------------------------------------------- products
  logic v7_q, v8_q;
  logic z7_q, z8_q;
  logic signed [35:0] xx_d, yy_d, zz_d, xy_d, xz_d, yz_d, xs_d, ys_d, zs_d;
  logic signed [35:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xs_q, ys_q, zs_q;
  logic signed [17:0] c7_q;
  logic signed [18:0] t7_d, t7_q;

  always_comb begin
    xx_d = 36'(u_q[0]) * 36'(u_q[0]);
    yy_d = 36'(u_q[1]) * 36'(u_q[1]);
    zz_d = 36'(u_q[2]) * 36'(u_q[2]);
    xy_d = 36'(u_q[0]) * 36'(u_q[1]);
    xz_d = 36'(u_q[0]) * 36'(u_q[2]);
    yz_d = 36'(u_q[1]) * 36'(u_q[2]);
    xs_d = 36'(u_q[0]) * 36'(s6_tr_q.s);
    ys_d = 36'(u_q[1]) * 36'(s6_tr_q.s);
    zs_d = 36'(u_q[2]) * 36'(s6_tr_q.s);
    t7_d = 19'(OneQ16) - 19'(s6_tr_q.c);
  end

  logic signed [35:0] wx, wy, wz;
  logic signed [55:0] p0_d, p4_d, p8_d, pxy_d, pxz_d, pyz_d;
  logic signed [55:0] p0_q, p4_q, p8_q, pxy_q, pxz_q, pyz_q;
  logic signed [35:0] xx8_q, yy8_q, zz8_q, xs8_q, ys8_q, zs8_q;

  always_comb begin
    wx    = (36'sd1 <<< 32) - xx_q;
    wy    = (36'sd1 <<< 32) - yy_q;
    wz    = (36'sd1 <<< 32) - zz_q;
    p0_d  = 56'(wx) * 56'(c7_q);
    p4_d  = 56'(wy) * 56'(c7_q);
    p8_d  = 56'(wz) * 56'(c7_q);
    pxy_d = 56'(xy_q) * 56'(t7_q);
    pxz_d = 56'(xz_q) * 56'(t7_q);
    pyz_d = 56'(yz_q) * 56'(t7_q);
  end

  // ---------------------------------------------------------------- output
  logic signed [55:0] e   [9];
  logic signed [55:0] er  [9];
  logic signed [17:0] mat_d [9];
  logic signed [17:0] mat_q [9];
  logic signed [55:0] xs16, ys16, zs16;
  logic               done_q;
  logic               zero_q;

  always_comb begin
    xs16 = 56'(xs8_q) <<< 16;
    ys16 = 56'(ys8_q) <<< 16;
    zs16 = 56'(zs8_q) <<< 16;
    e[0] = (56'(xx8_q) <<< 16) + p0_q;
    e[1] = pxy_q + zs16;
    e[2] = pxz_q - ys16;
    e[3] = pxy_q - zs16;
    e[4] = (56'(yy8_q) <<< 16) + p4_q;
    e[5] = pyz_q + xs16;
    e[6] = pxz_q + ys16;
    e[7] = pyz_q - xs16;
    e[8] = (56'(zz8_q) <<< 16) + p8_q;
    for (int k = 0; k < 9; k++) begin
      er[k] = e[k] + (56'sd1 <<< 31);
      if (z8_q) begin
        mat_d[k] = (k == 0 || k == 4 || k == 8) ? OneQ16 : ZeroQ16;
      end else begin
        mat_d[k] = sat_q16(er[k][55:32]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s6_v_q <= dv_v_q[DivSteps-1];
      v7_q   <= s6_v_q;
      v8_q   <= v7_q;
      done_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q       <= u_d;
    s6_tr_q   <= dv_tr_q[DivSteps-1];
    s6_zero_q <= (dv_ax_l.n2 == 32'd0);
    xx_q <= xx_d;
    yy_q <= yy_d;
    zz_q <= zz_d;
    xy_q <= xy_d;
    xz_q <= xz_d;
    yz_q <= yz_d;
    xs_q <= xs_d;
    ys_q <= ys_d;
    zs_q <= zs_d;
    c7_q <= s6_tr_q.c;
    t7_q <= t7_d;
    z7_q <= s6_zero_q;
    p0_q  <= p0_d;
    p4_q  <= p4_d;
    p8_q  <= p8_d;
    pxy_q <= pxy_d;
    pxz_q <= pxz_d;
    pyz_q <= pyz_d;
    xx8_q <= xx_q;
    yy8_q <= yy_q;
    zz8_q <= zz_q;
    xs8_q <= xs_q;
    ys8_q <= ys_q;
    zs8_q <= zs_q;
    z8_q  <= z7_q;
    mat_q  <= mat_d;
    zero_q <= z8_q;
  end

  assign done_o      = done_q;
  assign zero_axis_o = zero_q;
  assign m00_o = mat_q[0];
  assign m01_o = mat_q[1];
  assign m02_o = mat_q[2];
  assign m10_o = mat_q[3];
  assign m11_o = mat_q[4];
  assign m12_o = mat_q[5];
  assign m20_o = mat_q[6];
  assign m21_o = mat_q[7];
  assign m22_o = mat_q[8];

  // ---------------------------------------------------------------- checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("accepted beat did not come out after the pipeline latency");

  a_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result beat without a matching request beat");

  a_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_axis_o) |-> (m00_o == OneQ16 && m11_o == OneQ16 && m22_o == OneQ16
      && m01_o == ZeroQ16 && m02_o == ZeroQ16 && m10_o == ZeroQ16
      && m12_o == ZeroQ16 && m20_o == ZeroQ16 && m21_o == ZeroQ16))
    else $error("zero axis did not give the identity matrix");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_v_q |-> (u_q[0] <= OneQ16 && u_q[0] >= -OneQ16 && u_q[1] <= OneQ16
      && u_q[1] >= -OneQ16 && u_q[2] <= OneQ16 && u_q[2] >= -OneQ16))
    else $error("unit axis component out of range");

endmodule
